// File: hw/rtl/key_matrix_shift_debouncer_macros.svh
// Assertion macros shared by the debouncer RTL.
`ifndef KEY_MATRIX_SHIFT_DEBOUNCER_MACROS_SVH
`define KEY_MATRIX_SHIFT_DEBOUNCER_MACROS_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define KMSD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("debouncer assertion failed");

// Next-cycle implication, checked on i_clk outside reset.
`define KMSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("debouncer assertion failed");

`endif

// File: hw/rtl/kmsd_pkg.sv
// Types and constants of the key matrix debouncer.
package kmsd_pkg;

    localparam int HIST_W = 8;
    localparam int DEB_W  = 16;
    localparam int CFG_W  = 8;

    typedef logic [HIST_W-1:0] t_hist;
    typedef logic [DEB_W-1:0]  t_deb_row;
    typedef logic [7:0]        t_count;

    localparam t_hist    PRESS_BIT   = 8'h80;
    localparam logic [3:0] HALF_SPLIT = 4'd8;
    localparam t_count   COUNT_MAX   = 8'hFF;

    localparam logic [CFG_W-1:0] PRESS_THR_RST   = 8'd240;
    localparam logic [CFG_W-1:0] RELEASE_THR_RST = 8'd15;

    // Configuration register indexes
    localparam logic [1:0] CFG_PRESS_THR   = 2'd0;
    localparam logic [1:0] CFG_RELEASE_THR = 2'd1;

    typedef struct packed {
        logic [2:0] row_index;
        logic [3:0] scan_column;
        logic       raw_pressed;
        logic       scan_last;
    } t_in_item;

    typedef struct packed {
        logic [3:0] physical_column;
        logic       key_down;
        t_hist      sample_history;
        t_count     active_count;
        logic       scan_done;
    } t_out_item;

endpackage

// File: hw/rtl/kmsd_hist_mem.sv
// Per-key history memory with valid bits, registered read and write-to-read bypass.
module kmsd_hist_mem import kmsd_pkg::*; #(
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  t_hist                    i_wr_data,
    output t_hist                    o_rd_data
);
    t_hist              r_mem [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    t_hist              r_q;
    logic               r_q_vld;
    logic               r_byp;
    t_hist              r_byp_data;

    // Valid bits stand for the all-zero reset contents.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_q_vld    <= r_vld[i_rd_addr];
            r_byp      <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_byp_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : (r_q_vld ? r_q : '0);

endmodule

// File: hw/rtl/key_matrix_shift_debouncer.sv
// Top level of the key matrix shift-register debouncer.
//
//  channel   direction  handshake                     payload
//  -------   ---------  ----------------------------  -----------
//  in        input      i_in_valid / o_in_ready       i_in_data
//  out       output     o_out_valid / i_out_ready     o_out_data
//  cfg       input      i_cfg_we (no wait)            i_cfg_index, i_cfg_data
//
// One sample per cycle sustained while the output is taken. A transferred sample's history
// memory read is registered, then one update stage feeds the result register.
// Synchronous active-low reset clears the history valid bits, debounced rows and count.
// A stalled output holds the update stage; input ready drops only when both are full.
module key_matrix_shift_debouncer import kmsd_pkg::*; #(
    parameter int ROWS = 8,
    parameter int COLS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);
`include "key_matrix_shift_debouncer_macros.svh"

    localparam int DEPTH  = ROWS * COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Flat history index of a key
    function automatic logic [ADDR_W-1:0] key_addr(input logic [2:0] row,
                                                   input logic [3:0] scol);
        return ADDR_W'(32'(row) * COLS + 32'(scol));
    endfunction

    function automatic logic key_in_range(input logic [2:0] row, input logic [3:0] scol);
        return (32'(row) < ROWS) && (32'(scol) < COLS);
    endfunction

    logic [CFG_W-1:0] r_press_thr;
    logic [CFG_W-1:0] r_release_thr;

    logic       r_s1_valid;
    t_in_item   r_s1;
    logic       r_out_valid;
    t_out_item  r_out;
    t_count     r_count;
    t_deb_row   r_deb [ROWS];

    logic       in_xfer;
    logic       s1_adv;
    logic       s1_fire;
    logic       s1_hit;
    logic [ROW_W-1:0] s1_row;
    logic [3:0] s1_pcol;
    t_deb_row   s1_mask;
    t_hist      hist_old;
    t_hist      n_hist;
    t_deb_row   n_deb_row;
    t_count     n_count_inc;
    t_out_item  n_out;

    // ---------------------------------------------------------------
    // Configuration: plain writes, to be taken only while the block is idle (unenforced)
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_thr   <= PRESS_THR_RST;
            r_release_thr <= RELEASE_THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PRESS_THR:   r_press_thr   <= i_cfg_data;
                CFG_RELEASE_THR: r_release_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake: advance the update stage whenever the result register frees up
    // ---------------------------------------------------------------
    assign s1_adv     = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign s1_fire    = r_s1_valid && s1_adv;
    assign s1_hit     = key_in_range(r_s1.row_index, r_s1.scan_column);

    // History memory: read on input transfer, write back as an in-range update retires
    kmsd_hist_mem #(
        .DEPTH (DEPTH)
    ) u_hist_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_xfer),
        .i_rd_addr (key_addr(i_in_data.row_index, i_in_data.scan_column)),
        .i_wr_en   (s1_fire && s1_hit),
        .i_wr_addr (key_addr(r_s1.row_index, r_s1.scan_column)),
        .i_wr_data (n_hist),
        .o_rd_data (hist_old)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1 <= i_in_data;
        end
    end

    // ---------------------------------------------------------------
    // Update stage: shift, hysteresis compare, count
    // ---------------------------------------------------------------
    always_comb begin
        // Odd scan columns land in the upper half of the physical columns
        s1_pcol = (r_s1.scan_column >> 1) + (r_s1.scan_column[0] ? HALF_SPLIT : 4'd0);
        s1_row  = ROW_W'(r_s1.row_index);
        s1_mask = t_deb_row'(1) << s1_pcol;
        n_hist  = (hist_old >> 1) | (r_s1.raw_pressed ? PRESS_BIT : '0);

        // Press wins when both thresholds match
        if (n_hist >= r_press_thr) begin
            n_deb_row = r_deb[s1_row] | s1_mask;
        end else if (n_hist <= r_release_thr) begin
            n_deb_row = r_deb[s1_row] & ~s1_mask;
        end else begin
            n_deb_row = r_deb[s1_row];
        end

        n_count_inc = ((n_hist != '0) && (r_count != COUNT_MAX)) ? r_count + 8'd1 : r_count;

        n_out.physical_column = s1_pcol;
        n_out.scan_done       = r_s1.scan_last;
        if (s1_hit) begin
            n_out.key_down       = |(n_deb_row & s1_mask);
            n_out.sample_history = n_hist;
            n_out.active_count   = n_count_inc;
        end else begin
            // Key outside the matrix: zero down bit and history, no row or history write
            n_out.key_down       = 1'b0;
            n_out.sample_history = '0;
            n_out.active_count   = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_deb[r] <= '0;
            end
        end else if (s1_fire && s1_hit) begin
            r_deb[s1_row] <= n_deb_row;
        end
    end

    // Count restarts after the sample that ends a scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (s1_fire) begin
            r_count <= r_s1.scan_last ? '0 : n_out.active_count;
        end
    end

    // ---------------------------------------------------------------
    // Result register: hold until the downstream transfer
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `KMSD_ASSERT_NEXT(a_retire_shows_result, s1_fire, o_out_valid)
    `KMSD_ASSERT_NEXT(a_scan_end_clears_count, s1_fire && r_s1.scan_last, r_count == '0)
    `KMSD_ASSERT_NEXT(a_count_steps, s1_fire && s1_hit && !r_s1.scan_last && (n_hist != '0) && (r_count != COUNT_MAX), r_count == $past(r_count) + 8'd1)

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the key matrix shift-register debouncer.
`timescale 1ns / 100ps

module tb_top;
    import kmsd_pkg::*;

    // Quiet cycles allowed after the last result before checking the tail.
    localparam int TAIL_CYCLES = 6;
    // Length of the long output hold that backs the pipe up into the input.
    localparam int HOLD_CYCLES = 48;
    localparam int PHASES      = 6;

    typedef enum int {GEN_HOT, GEN_SCAN, GEN_NOLAST} t_gen_mode;

    // One row of the directed table: either a threshold change or a sample,
    // with a hand-typed expected result where one is given.
    typedef struct {
        bit          set_thr;
        logic [7:0]  thr_p;
        logic [7:0]  thr_r;
        t_in_item    smp;
        bit          typed;
        t_out_item   want;
    } t_stim_row;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    t_in_item         in_data = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out_item        out_data;
    logic             cfg_we = 1'b0;
    logic [1:0]       cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    // Predictor copy of the block's state and thresholds.
    t_hist            key_hist [128];
    t_deb_row         key_down_rows [8];
    t_count           scan_tally = '0;
    logic [CFG_W-1:0] thr_press = PRESS_THR_RST;
    logic [CFG_W-1:0] thr_release = RELEASE_THR_RST;

    t_out_item        expected_results [$];
    t_stim_row        dir_tab [$];

    // Idling controls for the sender and the receiver.
    bit               src_idle_en = 1'b1;
    bit               sink_idle_en = 1'b1;
    bit               hold_req = 1'b0;
    int               sink_stall = 0;

    // Hot keys of the current random phase and their intended switch levels.
    logic [2:0]       hot_row [4];
    logic [3:0]       hot_col [4];
    bit               hot_level [4];

    int               mismatches = 0;
    int               samples_sent = 0;
    int               directed_sent = 0;
    int               results_seen = 0;
    int               scans_closed = 0;
    int               saturated_seen = 0;
    int               keys_down_seen = 0;
    int               thr_settings = 0;
    int               long_holds = 0;

    key_matrix_shift_debouncer uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 4 ns clock: first rising edge at 2 ns, falling edges on multiples of 4 ns.
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predict one sample: shift the key history, update its debounced bit with
    // press taking priority over release, and bump the per-scan count.
    function automatic t_out_item debounce_predict(t_in_item s);
        t_out_item  r;
        logic [6:0] slot;
        logic [3:0] pcol;
        t_hist      h;
        pcol = {1'b0, s.scan_column[3:1]} + (s.scan_column[0] ? HALF_SPLIT : 4'd0);
        slot = {s.row_index, s.scan_column};
        h = (key_hist[slot] >> 1) | (s.raw_pressed ? PRESS_BIT : t_hist'(0));
        key_hist[slot] = h;
        if (h >= thr_press) begin
            key_down_rows[s.row_index][pcol] = 1'b1;
        end else if (h <= thr_release) begin
            key_down_rows[s.row_index][pcol] = 1'b0;
        end
        // Saturate instead of wrapping when no scan end arrives.
        if (h != '0 && scan_tally != COUNT_MAX) begin
            scan_tally = scan_tally + 8'd1;
        end
        r.physical_column = pcol;
        r.key_down        = key_down_rows[s.row_index][pcol];
        r.sample_history  = h;
        r.active_count    = scan_tally;
        r.scan_done       = s.scan_last;
        if (s.scan_last) begin
            scan_tally = '0;
        end
        return r;
    endfunction

    // Offer one sample, hold it until the transfer, then queue its expected
    // result. Called and returning at a falling edge.
    task automatic offer_sample(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item pred;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        pred = debounce_predict(it);
        expected_results.push_back(typed ? want : pred);
        samples_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait for every queued result, then let the pipe go quiet.
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (expected_results.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    // Write both thresholds on back-to-back cycles; the block is idle here.
    task automatic set_thresholds(input logic [7:0] p, input logic [7:0] r);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PRESS_THR;
        cfg_data  <= p;
        @(negedge clk);
        cfg_index <= CFG_RELEASE_THR;
        cfg_data  <= r;
        @(negedge clk);
        cfg_we    <= 1'b0;
        thr_press   = p;
        thr_release = r;
        thr_settings++;
    endtask

    task automatic add_thr(input logic [7:0] p, input logic [7:0] r);
        t_stim_row e;
        e = '{default: '0};
        e.set_thr = 1'b1;
        e.thr_p   = p;
        e.thr_r   = r;
        dir_tab.push_back(e);
    endtask

    task automatic add_step(input logic [2:0] row, input logic [3:0] col,
                            input bit raw, input bit last);
        t_stim_row e;
        e = '{default: '0};
        e.smp.row_index   = row;
        e.smp.scan_column = col;
        e.smp.raw_pressed = raw;
        e.smp.scan_last   = last;
        dir_tab.push_back(e);
    endtask

    task automatic add_typed(input logic [2:0] row, input logic [3:0] col,
                             input bit raw, input bit last,
                             input logic [3:0] pcol, input bit down,
                             input logic [7:0] hist, input logic [7:0] cnt, input bit done);
        add_step(row, col, raw, last);
        dir_tab[$].typed                = 1'b1;
        dir_tab[$].want.physical_column = pcol;
        dir_tab[$].want.key_down        = down;
        dir_tab[$].want.sample_history  = hist;
        dir_tab[$].want.active_count    = cnt;
        dir_tab[$].want.scan_done       = done;
    endtask

    // Receiver: drive ready at the falling edge. A long hold requested by the
    // stimulus is counted down here while the sender keeps offering samples.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall = sink_stall - 1;
            out_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req   = 1'b0;
            sink_stall = HOLD_CYCLES - 1;
            long_holds++;
            out_ready <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            sink_stall = $urandom_range(0, 6);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Check every output transfer against the oldest queued expectation.
    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] unexpected result: col=%0d down=%0b hist=%02h cnt=%0d done=%0b",
                             $realtime, out_data.physical_column, out_data.key_down,
                             out_data.sample_history, out_data.active_count, out_data.scan_done);
                end
            end else begin
                want = expected_results.pop_front();
                if (out_data.physical_column !== want.physical_column ||
                    out_data.key_down        !== want.key_down ||
                    out_data.sample_history  !== want.sample_history ||
                    out_data.active_count    !== want.active_count ||
                    out_data.scan_done       !== want.scan_done) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("[%0t] mismatch: exp col=%0d down=%0b hist=%02h cnt=%0d done=%0b",
                                 $realtime, want.physical_column, want.key_down,
                                 want.sample_history, want.active_count, want.scan_done);
                        $display("             got col=%0d down=%0b hist=%02h cnt=%0d done=%0b",
                                 out_data.physical_column, out_data.key_down,
                                 out_data.sample_history, out_data.active_count,
                                 out_data.scan_done);
                    end
                end
            end
            if (out_data.scan_done === 1'b1) scans_closed++;
            if (out_data.active_count === COUNT_MAX) saturated_seen++;
            if (out_data.key_down === 1'b1) keys_down_seen++;
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int        ph_press [PHASES] = '{240, 255,   0, 128, 240, -1};
        int        ph_rel   [PHASES] = '{ 15,   0, 255, 127,  15, -1};
        int        ph_len   [PHASES] = '{250, 200, 150, 300, 256, 150};
        t_gen_mode ph_mode  [PHASES] = '{GEN_HOT, GEN_HOT, GEN_HOT, GEN_NOLAST,
                                         GEN_SCAN, GEN_HOT};
        logic [7:0] p_val;
        logic [7:0] r_val;

        foreach (key_hist[k]) key_hist[k] = '0;
        foreach (key_down_rows[k]) key_down_rows[k] = '0;

        // Hold reset, then release it at a falling edge.
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table. Reset thresholds first: fresh keys, corner rows and
        // columns, and a zero history that must not be counted.
        add_typed(3'd0, 4'd0,  1'b1, 1'b0, 4'd0,  1'b0, 8'h80, 8'd1, 1'b0);
        add_typed(3'd7, 4'd15, 1'b1, 1'b0, 4'd15, 1'b0, 8'h80, 8'd2, 1'b0);
        add_typed(3'd7, 4'd15, 1'b0, 1'b1, 4'd15, 1'b0, 8'h40, 8'd3, 1'b1);
        add_typed(3'd0, 4'd1,  1'b0, 1'b0, 4'd8,  1'b0, 8'h00, 8'd0, 1'b0);
        // Press one key until its history saturates, then release it.
        repeat (8) add_step(3'd2, 4'd5, 1'b1, 1'b0);
        repeat (4) add_step(3'd2, 4'd5, 1'b0, 1'b0);
        add_step(3'd2, 4'd5, 1'b0, 1'b1);
        // Overlapping thresholds: a history meeting both compares is pressed.
        add_thr(8'd100, 8'd200);
        add_typed(3'd4, 4'd8,  1'b1, 1'b0, 4'd4,  1'b1, 8'h80, 8'd1, 1'b0);
        add_typed(3'd4, 4'd8,  1'b0, 1'b1, 4'd4,  1'b0, 8'h40, 8'd2, 1'b1);
        // Press threshold zero: even an empty history reads as down.
        add_thr(8'd0, 8'd0);
        add_typed(3'd1, 4'd6,  1'b0, 1'b0, 4'd3,  1'b1, 8'h00, 8'd0, 1'b0);
        add_typed(3'd1, 4'd6,  1'b1, 1'b1, 4'd3,  1'b1, 8'h80, 8'd1, 1'b1);
        // Both at the top: anything short of 0xFF releases.
        add_thr(8'd255, 8'd255);
        add_typed(3'd1, 4'd6,  1'b1, 1'b0, 4'd3,  1'b0, 8'hC0, 8'd1, 1'b0);
        add_typed(3'd6, 4'd10, 1'b0, 1'b0, 4'd5,  1'b0, 8'h00, 8'd1, 1'b0);
        add_typed(3'd5, 4'd3,  1'b1, 1'b1, 4'd9,  1'b0, 8'h80, 8'd2, 1'b1);

        foreach (dir_tab[n]) begin
            if (dir_tab[n].set_thr) begin
                settle();
                set_thresholds(dir_tab[n].thr_p, dir_tab[n].thr_r);
            end else begin
                offer_sample(dir_tab[n].smp, dir_tab[n].typed, dir_tab[n].want);
                directed_sent++;
            end
        end

        // Random phases: mostly a few hot keys with bounce on their levels,
        // plus stray keys; one phase without scan ends drives the count into
        // saturation, one walks the matrix in scan order.
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            p_val = (ph_press[ph] < 0) ? 8'($urandom_range(0, 255)) : 8'(ph_press[ph]);
            r_val = (ph_rel[ph] < 0)   ? 8'($urandom_range(0, 255)) : 8'(ph_rel[ph]);
            set_thresholds(p_val, r_val);
            for (int k = 0; k < 4; k++) begin
                hot_row[k]   = 3'($urandom_range(0, 7));
                hot_col[k]   = 4'($urandom_range(0, 15));
                hot_level[k] = (ph_mode[ph] == GEN_NOLAST) ? 1'b1 : 1'($urandom_range(0, 1));
            end
            // The last phase runs with no idling at all.
            src_idle_en  = (ph != PHASES - 1);
            sink_idle_en = (ph != PHASES - 1);
            if (ph == 0) hold_req = 1'b1;

            for (int i = 0; i < ph_len[ph]; i++) begin
                t_in_item s;
                int       j;
                j = $urandom_range(0, 3);
                if (ph_mode[ph] != GEN_NOLAST && $urandom_range(0, 11) == 0) begin
                    hot_level[j] = ~hot_level[j];
                end
                if (ph_mode[ph] == GEN_SCAN) begin
                    s.row_index   = i[6:4];
                    s.scan_column = i[3:0];
                    s.raw_pressed = ($urandom_range(0, 19) == 0);
                    for (int k = 0; k < 4; k++) begin
                        if (hot_row[k] == s.row_index && hot_col[k] == s.scan_column) begin
                            s.raw_pressed = hot_level[k];
                        end
                    end
                    s.scan_last = (i[6:0] == 7'h7F);
                end else begin
                    if ($urandom_range(0, 19) < 17) begin
                        s.row_index   = hot_row[j];
                        s.scan_column = hot_col[j];
                        s.raw_pressed = hot_level[j] ^ ($urandom_range(0, 7) == 0);
                    end else begin
                        s.row_index   = 3'($urandom_range(0, 7));
                        s.scan_column = 4'($urandom_range(0, 15));
                        s.raw_pressed = 1'($urandom_range(0, 1));
                    end
                    s.scan_last = (ph_mode[ph] == GEN_HOT) && ($urandom_range(0, 15) == 0);
                end
                offer_sample(s, 1'b0, '0);
            end
        end

        // Drain, then allow the tail for any stray result.
        settle();
        if (expected_results.size() != 0) mismatches++;

        $display("Run covered %0d samples (%0d directed) over %0d threshold settings,",
                 samples_sent, directed_sent, thr_settings);
        $display("%0d results, %0d scan ends, %0d saturated counts, %0d down keys, %0d long holds",
                 results_seen, scans_closed, saturated_seen, keys_down_seen, long_holds);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
